>>> rtl/core/qau_pkg.sv
// Shared types, constants and rounding and saturating helpers for the quaternion unit.
package qau_pkg;

	localparam int QAU_FRAC_BITS = 16;
	localparam int QAU_DW = 32;
	localparam logic [31:0] QAU_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] QAU_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		QAU_OP_MUL  = 2'd0,
		QAU_OP_ROT  = 2'd1,
		QAU_OP_ADD  = 2'd2,
		QAU_OP_NORM = 2'd3
	} qau_op_t;

	// request payload carried beside the normalize steps
	typedef struct packed {
		logic             use_q;
		logic [3:0]       neg;
		logic             ovf;
		logic [3:0][31:0] res;
	} qau_item_t;

	// round to nearest (ties up) dropping k bits, then saturate; returns {ovf, value}
	function automatic logic [32:0] qau_rnd_sat(input logic signed [99:0] v, input int k);
		logic signed [99:0] t;
		logic [32:0] r;
		t = (v + (100'sd1 <<< (k - 1))) >>> k;
		if ((&t[99:31]) || !(|t[99:31])) begin
			r = {1'b0, t[31:0]};
		end else begin
			r = {1'b1, t[99] ? QAU_MIN : QAU_MAX};
		end
		return r;
	endfunction

	function automatic logic [32:0] qau_sat_add(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] s;
		logic [32:0] r;
		s = 33'($signed(a)) + 33'($signed(b));
		if (s[32] == s[31]) begin
			r = {1'b0, s[31:0]};
		end else begin
			r = {1'b1, s[32] ? QAU_MIN : QAU_MAX};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/qau_prod.sv
// Front pipeline: products, sums, rotation partial products, rounding (stages 1 to 4).
module qau_prod import qau_pkg::*; #(
	parameter int FRAC_BITS = QAU_FRAC_BITS,
	localparam int RW = 2 * FRAC_BITS + 67
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [1:0]       op,
	input  logic [3:0][31:0] a,
	input  logic [3:0][31:0] b,
	output logic             out_vld,
	output qau_item_t        out_item,
	output logic [65:0]      out_s,
	output logic [3:0][RW-1:0] out_r
);

	// stage 1
	logic              vld_s1;
	qau_op_t           op_s1;
	logic [3:0][31:0]  a_s1, b_s1;
	logic signed [63:0] pab_s1 [4][4];
	logic signed [63:0] paa_s1 [4];

	// stage 2
	logic              vld_s2;
	qau_op_t           op_s2;
	logic [3:0][31:0]  a_s2, b_s2;
	logic signed [65:0] ham_s2 [4];
	logic signed [65:0] dot_s2, kk_s2;
	logic signed [65:0] crs_s2 [3];
	logic [65:0]       s_s2;
	logic [3:0][63:0]  paa_s2;
	logic [3:0][31:0]  res_s2;
	logic              ovf_s2;

	// stage 3
	logic              vld_s3;
	qau_op_t           op_s3;
	logic [3:0]        neg_s3;
	logic signed [65:0] rl_s3 [3][3];
	logic signed [64:0] rh_s3 [3][3];
	logic [65:0]       s_s3;
	logic [3:0][RW-1:0] r0_s3;
	logic [3:0][31:0]  res_s3;
	logic              ovf_s3;

	// stage 4
	logic              vld_s4;
	qau_item_t         item_s4;
	logic [65:0]       s_s4;
	logic [3:0][RW-1:0] r0_s4;

	logic [3:0][32:0]  add_c;
	logic [3:0][32:0]  ham_c;
	logic [2:0][32:0]  rot_c;
	logic signed [99:0] acc_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: all raw products
	always_ff @(posedge clk) begin
		op_s1 <= qau_op_t'(op);
		a_s1  <= a;
		b_s1  <= b;
		for (int i = 0; i < 4; i++) begin
			paa_s1[i] <= 64'($signed(a[i])) * 64'($signed(a[i]));
			for (int j = 0; j < 4; j++) begin
				pab_s1[i][j] <= 64'($signed(a[i])) * 64'($signed(b[j]));
			end
		end
	end

	// stage 2: sums of products, saturating lane adds
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			add_c[i] = qau_sat_add(a_s1[i], b_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		ham_s2[0] <= 66'(pab_s1[0][3]) + 66'(pab_s1[1][2]) - 66'(pab_s1[2][1])
			+ 66'(pab_s1[3][0]);
		ham_s2[1] <= -66'(pab_s1[0][2]) + 66'(pab_s1[1][3]) + 66'(pab_s1[2][0])
			+ 66'(pab_s1[3][1]);
		ham_s2[2] <= 66'(pab_s1[0][1]) - 66'(pab_s1[1][0]) + 66'(pab_s1[2][3])
			+ 66'(pab_s1[3][2]);
		ham_s2[3] <= -66'(pab_s1[0][0]) - 66'(pab_s1[1][1]) - 66'(pab_s1[2][2])
			+ 66'(pab_s1[3][3]);
		dot_s2 <= 66'(pab_s1[0][0]) + 66'(pab_s1[1][1]) + 66'(pab_s1[2][2]);
		kk_s2  <= 66'(paa_s1[3]) - 66'(paa_s1[0]) - 66'(paa_s1[1]) - 66'(paa_s1[2]);
		crs_s2[0] <= 66'(pab_s1[1][2]) - 66'(pab_s1[2][1]);
		crs_s2[1] <= 66'(pab_s1[2][0]) - 66'(pab_s1[0][2]);
		crs_s2[2] <= 66'(pab_s1[0][1]) - 66'(pab_s1[1][0]);
		s_s2 <= 66'(paa_s1[0]) + 66'(paa_s1[1]) + 66'(paa_s1[2]) + 66'(paa_s1[3]);
		for (int i = 0; i < 4; i++) begin
			paa_s2[i] <= paa_s1[i];
		end
		if (op_s1 == QAU_OP_ADD) begin
			for (int i = 0; i < 4; i++) begin
				res_s2[i] <= add_c[i][31:0];
			end
			ovf_s2 <= add_c[0][32] | add_c[1][32] | add_c[2][32] | add_c[3][32];
		end else begin
			res_s2 <= a_s1;
			ovf_s2 <= 1'b0;
		end
	end

	// stage 3: rotation partial products, product rounding
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ham_c[i] = qau_rnd_sat(100'(ham_s2[i]), FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		op_s3 <= op_s2;
		s_s3  <= s_s2;
		for (int i = 0; i < 4; i++) begin
			neg_s3[i] <= a_s2[i][31];
			r0_s3[i]  <= RW'(paa_s2[i]) << (2 * FRAC_BITS);
		end
		for (int i = 0; i < 3; i++) begin
			rl_s3[i][0] <= 66'($signed(a_s2[i])) * 66'($signed({1'b0, dot_s2[32:0]}));
			rh_s3[i][0] <= 65'($signed(a_s2[i])) * 65'($signed(dot_s2[65:33]));
			rl_s3[i][1] <= 66'($signed(b_s2[i])) * 66'($signed({1'b0, kk_s2[32:0]}));
			rh_s3[i][1] <= 65'($signed(b_s2[i])) * 65'($signed(kk_s2[65:33]));
			rl_s3[i][2] <= 66'($signed(a_s2[3])) * 66'($signed({1'b0, crs_s2[i][32:0]}));
			rh_s3[i][2] <= 65'($signed(a_s2[3])) * 65'($signed(crs_s2[i][65:33]));
		end
		if (op_s2 == QAU_OP_MUL) begin
			for (int i = 0; i < 4; i++) begin
				res_s3[i] <= ham_c[i][31:0];
			end
			ovf_s3 <= ham_c[0][32] | ham_c[1][32] | ham_c[2][32] | ham_c[3][32];
		end else begin
			res_s3 <= res_s2;
			ovf_s3 <= ovf_s2;
		end
	end

	// stage 4: rotation sums and rounding
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = (((100'(rh_s3[i][0]) <<< 33) + 100'(rl_s3[i][0])) <<< 1)
				+ ((100'(rh_s3[i][1]) <<< 33) + 100'(rl_s3[i][1]))
				+ (((100'(rh_s3[i][2]) <<< 33) + 100'(rl_s3[i][2])) <<< 1);
			rot_c[i] = qau_rnd_sat(acc_c[i], 2 * FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		s_s4  <= s_s3;
		r0_s4 <= r0_s3;
		item_s4.neg   <= neg_s3;
		item_s4.use_q <= (op_s3 == QAU_OP_NORM) && (|s_s3);
		if (op_s3 == QAU_OP_ROT) begin
			item_s4.res <= {32'd0, rot_c[2][31:0], rot_c[1][31:0], rot_c[0][31:0]};
			item_s4.ovf <= rot_c[0][32] | rot_c[1][32] | rot_c[2][32];
		end else begin
			item_s4.res <= res_s3;
			item_s4.ovf <= ovf_s3;
		end
	end

	assign out_vld  = vld_s4;
	assign out_item = item_s4;
	assign out_s    = s_s4;
	assign out_r    = r0_s4;

endmodule

>>> rtl/core/qau_nstep.sv
// One restoring step of the normalize quotient search, one bit for all four lanes.
module qau_nstep import qau_pkg::*; #(
	parameter int FRAC_BITS = QAU_FRAC_BITS,
	parameter int BIT = 0,
	localparam int RW = 2 * FRAC_BITS + 67,
	localparam int PW = FRAC_BITS + 66
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  qau_item_t          in_item,
	input  logic [65:0]        in_s,
	input  logic [3:0][RW-1:0] in_r,
	input  logic [3:0][PW-1:0] in_p,
	input  logic [3:0][FRAC_BITS:0] in_q,
	output logic               out_vld,
	output qau_item_t          out_item,
	output logic [65:0]        out_s,
	output logic [3:0][RW-1:0] out_r,
	output logic [3:0][PW-1:0] out_p,
	output logic [3:0][FRAC_BITS:0] out_q
);

	logic               vld_q;
	qau_item_t          item_q;
	logic [65:0]        s_q;
	logic [3:0][RW-1:0] r_q;
	logic [3:0][PW-1:0] p_q;
	logic [3:0][FRAC_BITS:0] q_q;
	logic [3:0][RW-1:0] dlt;
	logic [3:0]         ge;

	// residual R = m^2 * 2^2F - q^2 * S, P = q * S
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dlt[i] = (RW'(in_p[i]) << (BIT + 1)) + (RW'(in_s) << (2 * BIT));
			ge[i]  = in_r[i] >= dlt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= in_item;
		s_q    <= in_s;
		for (int i = 0; i < 4; i++) begin
			if (ge[i]) begin
				r_q[i] <= in_r[i] - dlt[i];
				p_q[i] <= in_p[i] + (PW'(in_s) << BIT);
				q_q[i] <= in_q[i] | ((FRAC_BITS + 1)'(1) << BIT);
			end else begin
				r_q[i] <= in_r[i];
				p_q[i] <= in_p[i];
				q_q[i] <= in_q[i];
			end
		end
	end

	assign out_vld  = vld_q;
	assign out_item = item_q;
	assign out_s    = s_q;
	assign out_r    = r_q;
	assign out_p    = p_q;
	assign out_q    = q_q;

endmodule

>>> rtl/core/quaternion_arith_unit.sv
// Quaternion unit top level: front arithmetic, normalize bit steps, result register.
//
//  channel  | handshake            | fields
//  request  | start (busy is low)  | opcode, a_x..a_w, b_x..b_w
//  result   | done, one cycle      | r_x, r_y, r_z, r_w, overflow
//
// One request per cycle for every opcode; the pipeline is four front stages,
// FRAC_BITS + 1 quotient bit steps and one output register.
// The bit steps of the normalize search set the depth.
// Reset clears the valid bits only; busy stays low, nothing ever stalls.
module quaternion_arith_unit import qau_pkg::*; #(
	parameter int FRAC_BITS = QAU_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] a_w,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	input  logic [31:0] b_w,
	output logic        done,
	output logic [31:0] r_x,
	output logic [31:0] r_y,
	output logic [31:0] r_z,
	output logic [31:0] r_w,
	output logic        overflow
);

	localparam int RW = 2 * FRAC_BITS + 67;
	localparam int PW = FRAC_BITS + 66;
	localparam int NSTEP = FRAC_BITS + 1;

	logic                    vld_c  [NSTEP+1];
	qau_item_t               item_c [NSTEP+1];
	logic [65:0]             s_c    [NSTEP+1];
	logic [3:0][RW-1:0]      r_c    [NSTEP+1];
	logic [3:0][PW-1:0]      p_c    [NSTEP+1];
	logic [3:0][FRAC_BITS:0] q_c    [NSTEP+1];

	logic              done_q;
	logic [3:0][31:0]  res_q;
	logic              ovf_q;
	qau_item_t         fin;
	logic [3:0][31:0]  qv;

	assign busy = 1'b0;

	qau_prod #(
		.FRAC_BITS(FRAC_BITS)
	) u_prod (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start & ~busy),
		.op      (opcode),
		.a       ({a_w, a_z, a_y, a_x}),
		.b       ({b_w, b_z, b_y, b_x}),
		.out_vld (vld_c[0]),
		.out_item(item_c[0]),
		.out_s   (s_c[0]),
		.out_r   (r_c[0])
	);

	assign p_c[0] = '0;
	assign q_c[0] = '0;

	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		qau_nstep #(
			.FRAC_BITS(FRAC_BITS),
			.BIT      (FRAC_BITS - j)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld_c[j]),
			.in_item (item_c[j]),
			.in_s    (s_c[j]),
			.in_r    (r_c[j]),
			.in_p    (p_c[j]),
			.in_q    (q_c[j]),
			.out_vld (vld_c[j+1]),
			.out_item(item_c[j+1]),
			.out_s   (s_c[j+1]),
			.out_r   (r_c[j+1]),
			.out_p   (p_c[j+1]),
			.out_q   (q_c[j+1])
		);
	end

	assign fin = item_c[NSTEP];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qv[i] = fin.neg[i] ? (32'd0 - 32'(q_c[NSTEP][i])) : 32'(q_c[NSTEP][i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_c[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (fin.use_q) begin
			res_q <= qv;
			ovf_q <= 1'b0;
		end else begin
			res_q <= fin.res;
			ovf_q <= fin.ovf;
		end
	end

	assign done     = done_q;
	assign r_x      = res_q[0];
	assign r_y      = res_q[1];
	assign r_z      = res_q[2];
	assign r_w      = res_q[3];
	assign overflow = ovf_q;

endmodule
